/* rtl/gra_pkg.sv */
// shared types and constants of the guillotine rectangle allocator
`default_nettype none
package gra_pkg;

  localparam int PORT_COORD_BITS = 16;
  localparam int COUNT_BITS      = 7;
  localparam int REGION_BITS     = 2;
  localparam int NUM_PIECES      = 4;

  // memory regions relative to the one that holds the live free list
  localparam logic [REGION_BITS-1:0] REG_OFS_L = 2'd1;
  localparam logic [REGION_BITS-1:0] REG_OFS_S = 2'd2;
  localparam logic [REGION_BITS-1:0] REG_OFS_P = 2'd3;

  typedef enum logic [1:0] {
    PC_BELOW = 2'd0,
    PC_ABOVE = 2'd1,
    PC_LEFT  = 2'd2,
    PC_RIGHT = 2'd3
  } piece_t;

  typedef enum logic [0:0] {
    CFG_ATLAS_WIDTH  = 1'b0,
    CFG_ATLAS_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

/* rtl/guillotine_rect_allocator_core.sv */
// top level of the guillotine rectangle allocator
`default_nettype none
// Places one image per request into the atlas and answers with one result.
// The free list and all scratch lists live in one ram with one read and one
// write port, split into four regions. A request scans the list of entries to
// find a fit; when it places, it copies the list, runs the containment pass on
// the entries after the split and the cut pass over survivors and work entries,
// all paced by the single ram read port. No request is taken while one is in
// work; a finished result waits in the output register.
module guillotine_rect_allocator_core #(
  parameter int MAX_FREE   = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [gra_pkg::PORT_COORD_BITS-1:0]  image_width,
  input  wire logic [gra_pkg::PORT_COORD_BITS-1:0]  image_height,
  input  wire logic                                 first_in_batch,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      placed,
  output logic      [gra_pkg::PORT_COORD_BITS-1:0]  pos_x,
  output logic      [gra_pkg::PORT_COORD_BITS-1:0]  pos_y,
  output logic      [gra_pkg::COUNT_BITS-1:0]       free_count,
  output logic                                      overflow,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire gra_pkg::cfg_reg_t                    cfg_index,
  input  wire logic [gra_pkg::PORT_COORD_BITS-1:0]  cfg_data
);
  import gra_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int RW    = 4 * CB;
  localparam int IW    = $clog2(MAX_FREE);
  localparam int CW    = $clog2(MAX_FREE + 1);
  localparam int AW    = REGION_BITS + IW;
  localparam int DEPTH = (2 ** REGION_BITS) * (2 ** IW);
  localparam logic [CW-1:0] MAXC = CW'(MAX_FREE);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_INIT    = 18'h00002,
    S_SCAN    = 18'h00004,
    S_COPY    = 18'h00008,
    S_PIECE_R = 18'h00010,
    S_PIECE_B = 18'h00020,
    S_CI_RD   = 18'h00040,
    S_CI_LD   = 18'h00080,
    S_CJ      = 18'h00100,
    S_OV_RD   = 18'h00200,
    S_OV_LD   = 18'h00400,
    S_CA_RD   = 18'h00800,
    S_CA_EV   = 18'h01000,
    S_CA_PC   = 18'h02000,
    S_CA_EM   = 18'h04000,
    S_CA_PUT  = 18'h08000,
    S_FINISH  = 18'h10000,
    S_DONE    = 18'h20000
  } state_t;

  state_t state;

  logic [CB-1:0] atlas_w, atlas_h, req_w, req_h, px, py;
  logic          found, ovf, rv, keep;
  logic [CW-1:0] cnt, ia, rj, sel, wc, oi, kc, ci, wn, mc;
  logic [REGION_BITS-1:0] cur, pr, qr;
  logic [RW-1:0] sr, ri, cr;
  logic [NUM_PIECES-1:0] pmask;
  logic [RW-1:0] pc [NUM_PIECES];

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  logic [NUM_PIECES-1:0] cut_mask;
  logic [RW-1:0]         cut_pieces [NUM_PIECES];

  logic [REGION_BITS-1:0] region_l, region_s;
  logic [CB-1:0] rd_x, rd_y, rd_w, rd_h, ri_x, ri_y, ri_w, ri_h;
  logic [CB-1:0] sr_x, sr_y, sr_w, sr_h;
  logic          fits, ins, same_r, cj_done, rcond, bcond, atlas_ok;
  logic [RW-1:0] right_piece, bottom_piece;
  piece_t        esel;

  gra_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gra_cut #(.COORD_BITS(CB)) u_cut (
    .clk    (clk),
    .load   (state == S_CA_EV),
    .f_rect (ram_rdata),
    .c_rect (cr),
    .mask   (cut_mask),
    .pieces (cut_pieces)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    region_l = cur + REG_OFS_L;
    region_s = cur + REG_OFS_S;
    rd_x = ram_rdata[RW-1 -: CB];
    rd_y = ram_rdata[3*CB-1 -: CB];
    rd_w = ram_rdata[2*CB-1 -: CB];
    rd_h = ram_rdata[CB-1:0];
    ri_x = ri[RW-1 -: CB];
    ri_y = ri[3*CB-1 -: CB];
    ri_w = ri[2*CB-1 -: CB];
    ri_h = ri[CB-1:0];
    sr_x = sr[RW-1 -: CB];
    sr_y = sr[3*CB-1 -: CB];
    sr_w = sr[2*CB-1 -: CB];
    sr_h = sr[CB-1:0];
    atlas_ok = (atlas_w != '0) && (atlas_h != '0);
    fits = (req_w <= rd_w) && (req_h <= rd_h);
    // entry ri lies inside the entry just read
    ins = (ri_x >= rd_x) && (ri_y >= rd_y) &&
          ({1'b0, ri_x} + {1'b0, ri_w} <= {1'b0, rd_x} + {1'b0, rd_w}) &&
          ({1'b0, ri_y} + {1'b0, ri_h} <= {1'b0, rd_y} + {1'b0, rd_h});
    same_r  = (ri == ram_rdata);
    cj_done = (ia == wc) && !rv;
    rcond = (sr_w > req_w) && (req_h != '0);
    bcond = (sr_w != '0) && (sr_h > req_h);
    right_piece  = {CB'(sr_x + req_w), sr_y, CB'(sr_w - req_w), req_h};
    bottom_piece = {sr_x, CB'(sr_y + req_h), sr_w, CB'(sr_h - req_h)};
    priority if (pmask[PC_BELOW]) esel = PC_BELOW;
    else if (pmask[PC_ABOVE])     esel = PC_ABOVE;
    else if (pmask[PC_LEFT])      esel = PC_LEFT;
    else                          esel = PC_RIGHT;
  end

  // ram port control
  always_comb begin
    ram_raddr = {cur, ia[IW-1:0]};
    ram_we    = 1'b0;
    ram_waddr = {cur, wc[IW-1:0]};
    ram_wdata = ram_rdata;
    unique case (state)
      S_INIT: begin
        ram_we    = atlas_ok;
        ram_waddr = {cur, {IW{1'b0}}};
        ram_wdata = {{CB{1'b0}}, {CB{1'b0}}, atlas_w, atlas_h};
      end
      S_COPY: begin
        ram_we    = rv && (rj != sel);
        ram_waddr = {region_l, wc[IW-1:0]};
      end
      S_PIECE_R: begin
        ram_we    = rcond && (wc < MAXC);
        ram_waddr = {region_l, wc[IW-1:0]};
        ram_wdata = right_piece;
      end
      S_PIECE_B: begin
        ram_we    = bcond && (wc < MAXC);
        ram_waddr = {region_l, wc[IW-1:0]};
        ram_wdata = bottom_piece;
      end
      S_CI_RD: ram_raddr = {region_l, oi[IW-1:0]};
      S_CJ: begin
        ram_raddr = {region_l, ia[IW-1:0]};
        ram_we    = cj_done && keep;
        ram_waddr = {region_s, kc[IW-1:0]};
        ram_wdata = ri;
      end
      S_OV_RD: ram_raddr = {region_s, oi[IW-1:0]};
      S_CA_RD: ram_raddr = {pr, ci[IW-1:0]};
      S_CA_EM: begin
        ram_we    = (pmask != '0) && (mc < MAXC);
        ram_waddr = {qr, mc[IW-1:0]};
        ram_wdata = pc[esel];
      end
      S_CA_PUT: begin
        ram_we    = mc < MAXC;
        ram_waddr = {qr, mc[IW-1:0]};
        ram_wdata = cr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      atlas_w   <= CB'(1024);
      atlas_h   <= CB'(1024);
      cnt       <= '0;
      ovf       <= 1'b0;
      cur       <= '0;
      out_valid <= 1'b0;
      rv        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ATLAS_WIDTH:  atlas_w <= cfg_data[CB-1:0];
          CFG_ATLAS_HEIGHT: atlas_h <= cfg_data[CB-1:0];
        endcase
      end
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_w     <= image_width[CB-1:0];
            req_h     <= image_height[CB-1:0];
            found     <= 1'b0;
            px        <= '0;
            py        <= '0;
            ia        <= '0;
            rv        <= 1'b0;
            state     <= first_in_batch ? S_INIT : S_SCAN;
          end
        end
        S_INIT: begin
          cnt   <= atlas_ok ? CW'(1) : '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (rv && fits) begin
            found <= 1'b1;
            sel   <= rj;
            sr    <= ram_rdata;
            px    <= rd_x;
            py    <= rd_y;
            ia    <= '0;
            rv    <= 1'b0;
            wc    <= '0;
            state <= S_COPY;
          end else if (ia < cnt) begin
            ia <= ia + CW'(1);
            rv <= 1'b1;
            rj <= ia;
          end else begin
            rv <= 1'b0;
            if (!rv) begin
              state <= S_DONE;
            end
          end
        end
        S_COPY: begin
          if (rv && (rj != sel)) begin
            wc <= wc + CW'(1);
          end
          if (ia < cnt) begin
            ia <= ia + CW'(1);
            rv <= 1'b1;
            rj <= ia;
          end else begin
            rv <= 1'b0;
            if (!rv) begin
              state <= S_PIECE_R;
            end
          end
        end
        S_PIECE_R: begin
          if (rcond) begin
            if (wc < MAXC) wc <= wc + CW'(1);
            else ovf <= 1'b1;
          end
          state <= S_PIECE_B;
        end
        S_PIECE_B: begin
          if (bcond) begin
            if (wc < MAXC) wc <= wc + CW'(1);
            else ovf <= 1'b1;
          end
          oi    <= '0;
          kc    <= '0;
          state <= S_CI_RD;
        end
        S_CI_RD: begin
          if (oi == wc) begin
            oi    <= '0;
            wn    <= '0;
            pr    <= cur + REG_OFS_P;
            qr    <= cur;
            state <= S_OV_RD;
          end else begin
            state <= S_CI_LD;
          end
        end
        S_CI_LD: begin
          ri    <= ram_rdata;
          keep  <= 1'b1;
          ia    <= '0;
          rv    <= 1'b0;
          state <= S_CJ;
        end
        S_CJ: begin
          // of identical twins only the earliest survives
          if (rv && (rj != oi) && ins && !(same_r && (rj > oi))) begin
            keep <= 1'b0;
          end
          if (ia < wc) begin
            ia <= ia + CW'(1);
            rv <= 1'b1;
            rj <= ia;
          end else begin
            rv <= 1'b0;
            if (!rv) begin
              if (keep) kc <= kc + CW'(1);
              oi    <= oi + CW'(1);
              state <= S_CI_RD;
            end
          end
        end
        S_OV_RD: begin
          state <= (oi == kc) ? S_FINISH : S_OV_LD;
        end
        S_OV_LD: begin
          cr    <= ram_rdata;
          ci    <= '0;
          mc    <= '0;
          state <= S_CA_RD;
        end
        S_CA_RD: begin
          if (ci == wn) begin
            state <= S_CA_PUT;
          end else begin
            ci    <= ci + CW'(1);
            state <= S_CA_EV;
          end
        end
        S_CA_EV: state <= S_CA_PC;
        S_CA_PC: begin
          pmask <= cut_mask;
          pc    <= cut_pieces;
          state <= S_CA_EM;
        end
        S_CA_EM: begin
          if (pmask == '0) begin
            state <= S_CA_RD;
          end else begin
            if (mc < MAXC) mc <= mc + CW'(1);
            else ovf <= 1'b1;
            pmask[esel] <= 1'b0;
          end
        end
        S_CA_PUT: begin
          if (mc < MAXC) wn <= mc + CW'(1);
          else begin
            wn  <= mc;
            ovf <= 1'b1;
          end
          pr    <= qr;
          qr    <= pr;
          oi    <= oi + CW'(1);
          state <= S_OV_RD;
        end
        S_FINISH: begin
          cur   <= pr;
          cnt   <= wn;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            placed     <= found;
            pos_x      <= PORT_COORD_BITS'(px);
            pos_y      <= PORT_COORD_BITS'(py);
            free_count <= COUNT_BITS'(cnt);
            overflow   <= ovf;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/gra_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module gra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/gra_cut.sv */
// two stage unit that cuts one rectangle out of a free rectangle
`default_nettype none
module gra_cut #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    load,
  input  wire logic [4*COORD_BITS-1:0] f_rect,
  input  wire logic [4*COORD_BITS-1:0] c_rect,
  output logic      [gra_pkg::NUM_PIECES-1:0] mask,
  output logic      [4*COORD_BITS-1:0] pieces [gra_pkg::NUM_PIECES]
);
  import gra_pkg::*;

  localparam int CB = COORD_BITS;

  logic [CB-1:0] fx, fy, fw, fh, x1, y1;
  logic [CB:0]   x2, y2, fx2, fy2;

  logic [CB-1:0] in_fx, in_fy, in_fw, in_fh, in_cx, in_cy, in_cw, in_ch;
  logic [CB:0]   in_fx2, in_fy2, in_cx2, in_cy2;
  logic          ovl;

  always_comb begin
    in_fx  = f_rect[4*CB-1 -: CB];
    in_fy  = f_rect[3*CB-1 -: CB];
    in_fw  = f_rect[2*CB-1 -: CB];
    in_fh  = f_rect[CB-1:0];
    in_cx  = c_rect[4*CB-1 -: CB];
    in_cy  = c_rect[3*CB-1 -: CB];
    in_cw  = c_rect[2*CB-1 -: CB];
    in_ch  = c_rect[CB-1:0];
    in_fx2 = {1'b0, in_fx} + {1'b0, in_fw};
    in_fy2 = {1'b0, in_fy} + {1'b0, in_fh};
    in_cx2 = {1'b0, in_cx} + {1'b0, in_cw};
    in_cy2 = {1'b0, in_cy} + {1'b0, in_ch};
  end

  // stage one: intersection bounds
  always_ff @(posedge clk) begin
    if (load) begin
      fx  <= in_fx;
      fy  <= in_fy;
      fw  <= in_fw;
      fh  <= in_fh;
      fx2 <= in_fx2;
      fy2 <= in_fy2;
      x1  <= (in_fx > in_cx) ? in_fx : in_cx;
      y1  <= (in_fy > in_cy) ? in_fy : in_cy;
      x2  <= (in_fx2 < in_cx2) ? in_fx2 : in_cx2;
      y2  <= (in_fy2 < in_cy2) ? in_fy2 : in_cy2;
    end
  end

  // stage two: the pieces left around the intersection
  always_comb begin
    ovl = ({1'b0, x1} < x2) && ({1'b0, y1} < y2);
    pieces[PC_ABOVE] = {fx, fy, fw, CB'(y1 - fy)};
    pieces[PC_LEFT]  = {fx, y1, CB'(x1 - fx), CB'(y2 - {1'b0, y1})};
    pieces[PC_RIGHT] = {x2[CB-1:0], y1, CB'(fx2 - x2), CB'(y2 - {1'b0, y1})};
    if (ovl) begin
      pieces[PC_BELOW] = {fx, y2[CB-1:0], fw, CB'(fy2 - y2)};
      mask[PC_BELOW]   = y2 < fy2;
      mask[PC_ABOVE]   = y1 > fy;
      mask[PC_LEFT]    = x1 > fx;
      mask[PC_RIGHT]   = x2 < fx2;
    end else begin
      // untouched rectangle passes through as the only piece
      pieces[PC_BELOW] = {fx, fy, fw, fh};
      mask             = '0;
      mask[PC_BELOW]   = 1'b1;
    end
  end

endmodule
`default_nettype wire

/* rtl/gra_checker.sv */
// port level checks of the allocator, bound to the top level
`default_nettype none
module gra_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic                                placed,
  input wire logic [gra_pkg::PORT_COORD_BITS-1:0] pos_x,
  input wire logic [gra_pkg::PORT_COORD_BITS-1:0] pos_y,
  input wire logic                                overflow
);

  // an accepted request keeps the block busy, so the input stalls on the next clock
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request input not stalled after a request was taken");

  a_unplaced_at_origin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !placed) |-> (pos_x == '0 && pos_y == '0))
    else $error("unplaced result with nonzero position");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |=> overflow)
    else $error("overflow flag cleared without reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(placed) && $stable(pos_x) && $stable(pos_y)))
    else $error("result changed while stalled");

endmodule

bind guillotine_rect_allocator_core gra_checker u_gra_checker (.*);
`default_nettype wire

/* tb/tb_guillotine_rect_allocator_core.sv */
// self-checking testbench of the guillotine rectangle allocator core
`timescale 1ns / 100ps
`default_nettype none
module tb_guillotine_rect_allocator_core;
  import gra_pkg::*;

  localparam int LIST_DEPTH = 64;

  typedef struct {
    int unsigned x, y, w, h;
  } rect_t;

  typedef struct {
    logic [15:0] w;
    logic [15:0] h;
    logic        first;
  } request_t;

  typedef struct {
    logic        placed;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [6:0]  free_count;
    logic        overflow;
  } placement_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        first_in_batch;
  logic        out_valid;
  logic        out_stall;
  logic        placed;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [6:0]  free_count;
  logic        overflow;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_reg_t    cfg_index;
  logic [15:0] cfg_data;

  guillotine_rect_allocator_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .image_width(image_width), .image_height(image_height),
    .first_in_batch(first_in_batch),
    .out_valid(out_valid), .out_stall(out_stall),
    .placed(placed), .pos_x(pos_x), .pos_y(pos_y),
    .free_count(free_count), .overflow(overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  int unsigned atlas_w = 1024;
  int unsigned atlas_h = 1024;
  rect_t       free_rects[LIST_DEPTH];
  int unsigned free_n;
  bit          overflow_seen;
  rect_t       work_a[LIST_DEPTH];
  rect_t       work_b[LIST_DEPTH];
  rect_t       survivors[LIST_DEPTH];
  int unsigned work_a_n, work_b_n;

  request_t    request_q[$];
  placement_t  placement_q[$];
  int          errors;
  int          gap_left;
  bit          no_idle;
  bit          hold_go;
  bit          hold_done;
  int          hold_cnt;
  int          stall_left;

  function automatic rect_t mk_rect(int unsigned x, int unsigned y, int unsigned w,
                                    int unsigned h);
    rect_t r;
    r.x = x; r.y = y; r.w = w; r.h = h;
    return r;
  endfunction

  function automatic void push_free(rect_t r);
    if (free_n < LIST_DEPTH) begin
      free_rects[free_n] = r;
      free_n++;
    end else overflow_seen = 1'b1;
  endfunction

  function automatic void push_b(rect_t r);
    if (work_b_n < LIST_DEPTH) begin
      work_b[work_b_n] = r;
      work_b_n++;
    end else overflow_seen = 1'b1;
  endfunction

  // containment pass followed by cutting each survivor out of those accepted before it
  function automatic void tidy_free_list();
    int unsigned kept;
    bit keep;
    rect_t s, b, f, c;
    int unsigned fx2, fy2, x1, y1, x2, y2;
    kept = 0;
    for (int i = 0; i < free_n; i++) begin
      keep = 1'b1;
      s = free_rects[i];
      for (int j = 0; j < free_n && keep; j++) begin
        if (i == j) continue;
        b = free_rects[j];
        if (s.x >= b.x && s.y >= b.y && s.x + s.w <= b.x + b.w && s.y + s.h <= b.y + b.h &&
            !(s.x == b.x && s.y == b.y && s.w == b.w && s.h == b.h && j > i))
          keep = 1'b0;
      end
      if (keep) begin
        survivors[kept] = s;
        kept++;
      end
    end
    work_a_n = 0;
    for (int k = 0; k < kept; k++) begin
      c = survivors[k];
      work_b_n = 0;
      for (int i = 0; i < work_a_n; i++) begin
        f = work_a[i];
        fx2 = f.x + f.w;
        fy2 = f.y + f.h;
        x1 = (f.x > c.x) ? f.x : c.x;
        y1 = (f.y > c.y) ? f.y : c.y;
        x2 = (fx2 < c.x + c.w) ? fx2 : c.x + c.w;
        y2 = (fy2 < c.y + c.h) ? fy2 : c.y + c.h;
        if (x1 >= x2 || y1 >= y2) begin
          push_b(f);
          continue;
        end
        if (y2 < fy2) push_b(mk_rect(f.x, y2, f.w, fy2 - y2));
        if (y1 > f.y) push_b(mk_rect(f.x, f.y, f.w, y1 - f.y));
        if (x1 > f.x) push_b(mk_rect(f.x, y1, x1 - f.x, y2 - y1));
        if (x2 < fx2) push_b(mk_rect(x2, y1, fx2 - x2, y2 - y1));
      end
      for (int i = 0; i < work_b_n; i++) work_a[i] = work_b[i];
      work_a_n = work_b_n;
      if (work_a_n < LIST_DEPTH) begin
        work_a[work_a_n] = c;
        work_a_n++;
      end else overflow_seen = 1'b1;
    end
    for (int i = 0; i < work_a_n; i++) free_rects[i] = work_a[i];
    free_n = work_a_n;
  endfunction

  function automatic placement_t place_image(request_t rq);
    placement_t res;
    int unsigned w, h, sel;
    bit found;
    rect_t s;
    w = rq.w;
    h = rq.h;
    found = 1'b0;
    sel = 0;
    if (rq.first) begin
      free_n = 0;
      if (atlas_w > 0 && atlas_h > 0) begin
        free_rects[0] = mk_rect(0, 0, atlas_w, atlas_h);
        free_n = 1;
      end
    end
    for (int i = 0; i < free_n; i++) begin
      if (w <= free_rects[i].w && h <= free_rects[i].h) begin
        sel = i;
        found = 1'b1;
        break;
      end
    end
    res.pos_x = '0;
    res.pos_y = '0;
    if (found) begin
      s = free_rects[sel];
      res.pos_x = s.x[15:0];
      res.pos_y = s.y[15:0];
      for (int i = sel; i + 1 < free_n; i++) free_rects[i] = free_rects[i + 1];
      free_n--;
      if (s.w > w && h > 0) push_free(mk_rect(s.x + w, s.y, s.w - w, h));
      if (s.w > 0 && s.h > h) push_free(mk_rect(s.x, s.y + h, s.w, s.h - h));
      tidy_free_list();
    end
    res.placed = found;
    res.free_count = free_n[6:0];
    res.overflow = overflow_seen;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    request_t rq;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        rq.w = image_width;
        rq.h = image_height;
        rq.first = first_in_batch;
        placement_q.insert(placement_q.size(), place_image(rq));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          rq = request_q.pop_front();
          image_width <= rq.w;
          image_height <= rq.h;
          first_in_batch <= rq.first;
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk) begin
    placement_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_cnt = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (placement_q.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          exp_r = placement_q.pop_front();
          if (placed !== exp_r.placed) begin
            $error("placed: expected %0d got %0d", exp_r.placed, placed); errors++;
          end
          if (pos_x !== exp_r.pos_x) begin
            $error("pos_x: expected %0d got %0d", exp_r.pos_x, pos_x); errors++;
          end
          if (pos_y !== exp_r.pos_y) begin
            $error("pos_y: expected %0d got %0d", exp_r.pos_y, pos_y); errors++;
          end
          if (free_count !== exp_r.free_count) begin
            $error("free_count: expected %0d got %0d", exp_r.free_count, free_count);
            errors++;
          end
          if (overflow !== exp_r.overflow) begin
            $error("overflow: expected %0d got %0d", exp_r.overflow, overflow); errors++;
          end
        end
      end
      // long hold-off so the block backs up and stalls its input
      if (hold_go && !hold_done) begin
        hold_cnt++;
        out_stall <= 1'b1;
        if (hold_cnt >= 3000) hold_done = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  task automatic add_request(int w, int h, bit first);
    request_t rq;
    rq.w = w[15:0];
    rq.h = h[15:0];
    rq.first = first;
    request_q.insert(request_q.size(), rq);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (request_q.size() > 0 || placement_q.size() > 0 || in_valid);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    if (idx == CFG_ATLAS_WIDTH) atlas_w = value & 16'hffff;
    else atlas_h = value & 16'hffff;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // batch of random requests, mostly small images so many get placed
  task automatic random_batch(int count, int unsigned aw, int unsigned ah);
    int w, h, r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0) begin
        w = $urandom_range(1, 65535);
        h = $urandom_range(1, 65535);
      end else begin
        w = $urandom_range(1, (aw > 4) ? aw / 4 : 1);
        h = $urandom_range(1, (ah > 4) ? ah / 4 : 1);
      end
      add_request(w, h, (i == 0) || ($urandom_range(0, 11) == 0));
    end
  endtask

  initial begin
    errors = 0;
    no_idle = 1'b0;
    hold_go = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    image_width = '0;
    image_height = '0;
    first_in_batch = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ATLAS_WIDTH;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: no batch yet, full fit, zero sizes, no fit
    add_request(1, 1, 1'b0);
    add_request(1024, 1024, 1'b1);
    add_request(1, 1, 1'b0);
    add_request(0, 0, 1'b1);
    add_request(1024, 0, 1'b0);
    add_request(0, 1024, 1'b0);
    add_request(65535, 1, 1'b0);
    add_request(100, 200, 1'b1);
    add_request(300, 50, 1'b0);
    add_request(924, 824, 1'b0);
    add_request(1, 65535, 1'b0);
    wait_drained();

    write_reg(CFG_ATLAS_WIDTH, 65535);
    write_reg(CFG_ATLAS_HEIGHT, 65535);
    add_request(65535, 65535, 1'b1);
    add_request(43690, 21845, 1'b1);
    add_request(21845, 43690, 1'b0);
    add_request(21845, 21845, 1'b0);
    wait_drained();

    write_reg(CFG_ATLAS_WIDTH, 0);
    add_request(1, 1, 1'b1);
    add_request(0, 0, 1'b1);
    wait_drained();

    write_reg(CFG_ATLAS_WIDTH, 1);
    write_reg(CFG_ATLAS_HEIGHT, 1);
    add_request(1, 1, 1'b1);
    add_request(1, 1, 1'b0);
    add_request(2, 1, 1'b1);
    wait_drained();

    write_reg(CFG_ATLAS_WIDTH, 1024);
    write_reg(CFG_ATLAS_HEIGHT, 1024);
    no_idle = 1'b1;
    random_batch(25, 1024, 1024);
    wait_drained();

    no_idle = 1'b0;
    hold_go = 1'b1;
    random_batch(25, 1024, 1024);
    wait_drained();

    write_reg(CFG_ATLAS_WIDTH, 37);
    write_reg(CFG_ATLAS_HEIGHT, 300);
    random_batch(20, 37, 300);
    wait_drained();

    write_reg(CFG_ATLAS_WIDTH, $urandom_range(1, 65535));
    write_reg(CFG_ATLAS_HEIGHT, $urandom_range(1, 65535));
    random_batch(20, atlas_w, atlas_h);
    add_request(16'h5555, 16'haaaa, 1'b1);
    add_request(16'haaaa, 16'h5555, 1'b1);
    wait_drained();
    repeat (50) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #500ms;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
rtl/gra_pkg.sv
rtl/gra_ram.sv
rtl/gra_cut.sv
rtl/guillotine_rect_allocator_core.sv
rtl/gra_checker.sv
tb/tb_guillotine_rect_allocator_core.sv
